### src/rlycd_pkg.sv
// Shared types, character codes and helpers for the serial relay command decoder.
package rlycd_pkg;

    localparam int CHAR_W    = 8;
    localparam int NUM_CHARS = 3;
    localparam int SECS_W    = 7;
    localparam int OUT_W     = 16;

    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UP_F  = 8'h46;
    localparam logic [CHAR_W-1:0] CH_UP_L  = 8'h4C;
    localparam logic [CHAR_W-1:0] CH_UP_N  = 8'h4E;
    localparam logic [CHAR_W-1:0] CH_UP_O  = 8'h4F;
    localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7A;
    localparam logic [CHAR_W-1:0] CASE_OFS = 8'h20;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_OK   = 2'd1,
        EV_BAD  = 2'd2,
        EV_DONE = 2'd3
    } event_t;

    typedef struct packed {
        logic [NUM_CHARS-1:0][CHAR_W-1:0] char_store;
        logic [1:0]                       char_count;
        logic                             light_on;
        logic                             fan_on;
        logic [SECS_W-1:0]                countdown;
    } relay_state_t;

    function automatic logic [CHAR_W-1:0] upcase(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= CH_LO_A && c <= CH_LO_Z) begin
            r = c - CASE_OFS;
        end
        return r;
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

### src/rlycd_step.sv
// Next-state and event logic for one byte or tick beat.
module rlycd_step (
    input  rlycd_pkg::relay_state_t         state,
    input  logic                            is_tick,
    input  logic [rlycd_pkg::CHAR_W-1:0]    rx_byte,
    output rlycd_pkg::relay_state_t         state_next,
    output rlycd_pkg::event_t               ev
);

    logic [rlycd_pkg::CHAR_W-1:0] c0, c1, c2;
    logic [3:0]                   d1, d2;
    logic [rlycd_pkg::SECS_W-1:0] dur;
    logic                         timed_form;
    logic                         w_lon, w_lof, w_fon, w_fof;
    logic [rlycd_pkg::SECS_W-1:0] cnt_dec;

    // Third character is the incoming byte when a command completes.
    assign c0 = state.char_store[0];
    assign c1 = state.char_store[1];
    assign c2 = rx_byte;

    assign d1  = 4'(c1 - rlycd_pkg::CH_ZERO);
    assign d2  = 4'(c2 - rlycd_pkg::CH_ZERO);
    // d1 * 10 as two shifts
    assign dur = {d1, 3'b000} + {2'b00, d1, 1'b0} + {3'b000, d2};

    assign timed_form = (c0 == rlycd_pkg::CH_UP_L) && rlycd_pkg::is_digit(c1)
                        && rlycd_pkg::is_digit(c2);

    assign w_lon = rlycd_pkg::upcase(c0) == rlycd_pkg::CH_UP_L
                   && rlycd_pkg::upcase(c1) == rlycd_pkg::CH_UP_O
                   && rlycd_pkg::upcase(c2) == rlycd_pkg::CH_UP_N;
    assign w_lof = rlycd_pkg::upcase(c0) == rlycd_pkg::CH_UP_L
                   && rlycd_pkg::upcase(c1) == rlycd_pkg::CH_UP_O
                   && rlycd_pkg::upcase(c2) == rlycd_pkg::CH_UP_F;
    assign w_fon = rlycd_pkg::upcase(c0) == rlycd_pkg::CH_UP_F
                   && rlycd_pkg::upcase(c1) == rlycd_pkg::CH_UP_O
                   && rlycd_pkg::upcase(c2) == rlycd_pkg::CH_UP_N;
    assign w_fof = rlycd_pkg::upcase(c0) == rlycd_pkg::CH_UP_F
                   && rlycd_pkg::upcase(c1) == rlycd_pkg::CH_UP_O
                   && rlycd_pkg::upcase(c2) == rlycd_pkg::CH_UP_F;

    assign cnt_dec = state.countdown - 1'b1;

    always_comb begin
        state_next = state;
        ev         = rlycd_pkg::EV_NONE;
        if (is_tick) begin
            if (state.countdown != '0) begin
                state_next.countdown = cnt_dec;
                if (cnt_dec == '0) begin
                    state_next.light_on = 1'b0;
                    ev                  = rlycd_pkg::EV_DONE;
                end
            end
        end else if (state.countdown == '0) begin
            if (rx_byte == rlycd_pkg::CH_LF || rx_byte == rlycd_pkg::CH_CR) begin
                // count never reaches three here, so the command is short
                ev                    = rlycd_pkg::EV_BAD;
                state_next.char_count = 2'd0;
            end else if (state.char_count < 2'd2) begin
                state_next.char_store[state.char_count] = rx_byte;
                state_next.char_count = state.char_count + 2'd1;
            end else begin
                state_next.char_store[2] = rx_byte;
                state_next.char_count    = 2'd0;
                ev                       = rlycd_pkg::EV_BAD;
                if (timed_form) begin
                    if (dur != '0) begin
                        state_next.countdown = dur;
                        state_next.light_on  = 1'b1;
                        ev                   = rlycd_pkg::EV_OK;
                    end
                end else if (w_lon) begin
                    state_next.light_on = 1'b1;
                    ev                  = rlycd_pkg::EV_OK;
                end else if (w_lof) begin
                    state_next.light_on = 1'b0;
                    ev                  = rlycd_pkg::EV_OK;
                end else if (w_fon) begin
                    state_next.fan_on = 1'b1;
                    ev                = rlycd_pkg::EV_OK;
                end else if (w_fof) begin
                    state_next.fan_on = 1'b0;
                    ev                = rlycd_pkg::EV_OK;
                end
            end
        end
    end

endmodule

### src/serial_relay_command_decoder.sv
// Top level of the serial relay command decoder: input register, step logic, result register.
// Each beat goes from the input register through the step logic into the result register.
// Throughput: one beat per cycle; the input register and the result register each
// advance whenever the stage after them is empty or drains in the same cycle.
// Reset (aresetn low, synchronous): both registers empty, command buffer, char
// count, relays and countdown cleared.
module serial_relay_command_decoder (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input beat
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rlycd_pkg::CHAR_W-1:0]  s_tdata,   // [7:0] rx_byte
    input  logic                          s_tuser,   // [0] operation (1 = tick)
    // result beat
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rlycd_pkg::OUT_W-1:0]   m_tdata    // [0] light_relay, [1] fan_relay,
                                                     // [3:2] event_res, [10:4] seconds_left
);

    // Input register
    logic                          in_valid_reg;
    logic                          in_tick_reg;
    logic [rlycd_pkg::CHAR_W-1:0]  in_byte_reg;

    // Decoder state
    rlycd_pkg::relay_state_t       state_reg;
    rlycd_pkg::relay_state_t       state_next;
    rlycd_pkg::event_t             ev;

    // Result register
    logic                          out_valid_reg;
    logic [rlycd_pkg::OUT_W-1:0]   out_data_reg;
    logic [rlycd_pkg::OUT_W-1:0]   out_data_next;

    logic                          advance;

    // Process the held beat when the result register is free or drains now.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    // Take a new beat whenever the input register is empty or empties this cycle.
    assign s_tready = !in_valid_reg || advance;

    rlycd_step u_step (
        .state      (state_reg),
        .is_tick    (in_tick_reg),
        .rx_byte    (in_byte_reg),
        .state_next (state_next),
        .ev         (ev)
    );

    // Pack the result: relays, event code, then seconds left, zero-filled to 16 bits.
    assign out_data_next = {5'b00000, state_next.countdown, ev,
                            state_next.fan_on, state_next.light_on};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Hold the payload while the beat waits; load on every accept.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_tick_reg <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    // Advance the command state once per processed beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
